@@ design/vgpa_pkg.sv @@
// package for the voxel grid point averager: sizes, codes, cell word layout
// used by design/voxel_grid_point_averager.sv, depends on nothing
`default_nettype none
package vgpa_pkg;

  localparam int GRID_X       = 128;
  localparam int GRID_Y       = 128;
  localparam int GRID_Z       = 64;
  localparam int VOXEL_STEP   = 32;
  localparam int SOURCE_SLOTS = 10;
  localparam int MAX_SOURCES  = 64;

  localparam int GX_W     = $clog2(GRID_X);
  localparam int GY_W     = $clog2(GRID_Y);
  localparam int GZ_W     = $clog2(GRID_Z);
  localparam int CELL_AW  = GX_W + GY_W + GZ_W;
  localparam int CELLS    = GRID_X * GRID_Y * GRID_Z;
  localparam int STEP_SH  = $clog2(VOXEL_STEP);
  localparam int SRC_AW   = $clog2(MAX_SOURCES);
  localparam int ID_W     = 6;
  localparam int LIST_W   = ID_W * SOURCE_SLOTS;
  localparam int COORD_W  = 24;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 16;
  localparam int VOX_W    = 26;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_AVG   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1,
    REG_REF_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EVAL,
    ST_RAW,
    ST_RD_RD,
    ST_RD_EVAL,
    ST_DIV,
    ST_ORG_RD,
    ST_ORG_OUT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [SUM_W-1:0]  sum_z;
    logic [LIST_W-1:0]        list;
  } cell_t;

endpackage
`default_nettype wire

@@ design/voxel_grid_point_averager.sv @@
// voxel grid point averager top level: cell store, origin table, divider, sequencer; uses vgpa_pkg
// sequence: load writes the origin table on acceptance; insert reads the cell, then writes it back
// or gives a raw beat (also outside the grid); read gives an empty beat, else runs a serial divider
// (one quotient bit per cycle per axis), then per source an origin table read and a source beat
// throughput: one item at a time, set by the single-port cell memory and divider
// reset: synchronous rst_n clears registers, then a pass zeroes all 1048576 cells, in_tready low
`default_nettype none
module voxel_grid_point_averager (
  input  wire          clk,
  input  wire          rst_n,
  // input beats
  input  wire          in_tvalid,
  output logic         in_tready,
  // source_id, origin_x, origin_y, origin_z, point_x, point_y, point_z,
  // read_cell_x, read_cell_y, read_cell_z, zero fill
  input  wire  [175:0] in_tdata,
  input  wire  [1:0]   in_tuser,   // cmd
  // result beats
  output logic         out_tvalid,
  input  wire          out_tready,
  // out_origin_x, out_origin_y, out_origin_z, out_point_x, out_point_y, out_point_z
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast,  // last
  // configuration writes
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_addr,
  input  wire  [23:0]  cfg_data
);

  localparam int CW = vgpa_pkg::COORD_W;
  localparam int SW = vgpa_pkg::SUM_W;
  localparam int NW = vgpa_pkg::COUNT_W;
  localparam int AW = vgpa_pkg::CELL_AW;
  localparam int IW = vgpa_pkg::ID_W;
  localparam int LW = vgpa_pkg::LIST_W;
  localparam int VW = vgpa_pkg::VOX_W;

  // input field slices
  logic [IW-1:0]        f_sid;
  logic signed [CW-1:0] f_ox, f_oy, f_oz, f_px, f_py, f_pz;
  logic [6:0]           f_rx, f_ry;
  logic [5:0]           f_rz;
  assign f_sid = in_tdata[5:0];
  assign f_ox  = in_tdata[29:6];
  assign f_oy  = in_tdata[53:30];
  assign f_oz  = in_tdata[77:54];
  assign f_px  = in_tdata[101:78];
  assign f_py  = in_tdata[125:102];
  assign f_pz  = in_tdata[149:126];
  assign f_rx  = in_tdata[156:150];
  assign f_ry  = in_tdata[163:157];
  assign f_rz  = in_tdata[169:164];

  // config registers, always writable
  logic signed [CW-1:0] ref_x_r, ref_y_r, ref_z_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_z_r <= '0;
    end else if (cfg_valid) begin
      unique case (vgpa_pkg::reg_idx_t'(cfg_addr))
        vgpa_pkg::REG_REF_X: ref_x_r <= cfg_data;
        vgpa_pkg::REG_REF_Y: ref_y_r <= cfg_data;
        vgpa_pkg::REG_REF_Z: ref_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // voxel index per axis: truncating shift of offset point plus half grid
  function automatic logic signed [VW-1:0] vox(input logic signed [CW-1:0] p,
                                                input logic signed [CW-1:0] r,
                                                input int half);
    logic signed [VW-1:0] d;
    logic signed [VW-1:0] b;
    begin
      d = VW'(p) - VW'(r);
      b = d[VW-1] ? d + VW'(vgpa_pkg::VOXEL_STEP - 1) : d;
      vox = (b >>> vgpa_pkg::STEP_SH) + VW'(half);
    end
  endfunction

  logic signed [VW-1:0] vx, vy, vz;
  logic                 vox_ok, rd_ok;
  assign vx = vox(f_px, ref_x_r, vgpa_pkg::GRID_X / 2);
  assign vy = vox(f_py, ref_y_r, vgpa_pkg::GRID_Y / 2);
  assign vz = vox(f_pz, ref_z_r, vgpa_pkg::GRID_Z / 2);
  assign vox_ok = !vx[VW-1] && (vx < VW'(vgpa_pkg::GRID_X)) &&
                  !vy[VW-1] && (vy < VW'(vgpa_pkg::GRID_Y)) &&
                  !vz[VW-1] && (vz < VW'(vgpa_pkg::GRID_Z));
  assign rd_ok  = (32'(f_rx) < vgpa_pkg::GRID_X) && (32'(f_ry) < vgpa_pkg::GRID_Y) &&
                  (32'(f_rz) < vgpa_pkg::GRID_Z);

  // sequencer registers
  vgpa_pkg::state_t     state_r, state_nxt;
  logic [AW:0]          clr_r;
  logic [AW-1:0]        addr_r;
  logic                 ok_r;
  logic [IW-1:0]        sid_r;
  logic signed [CW-1:0] ox_r, oy_r, oz_r, px_r, py_r, pz_r;
  vgpa_pkg::cell_t      work_r;
  logic [LW-1:0]        list_r;
  logic signed [CW-1:0] avg_r [3];
  logic [1:0]           axis_r;
  logic [5:0]           dcnt_r;
  logic [NW:0]          rem_r;
  logic [SW-1:0]        quo_r;
  logic                 neg_r;

  // cell memory, one port, registered read
  vgpa_pkg::cell_t cell_mem [vgpa_pkg::CELLS];
  vgpa_pkg::cell_t cell_rd_r;
  logic            cm_re, cm_we;
  logic [AW-1:0]   cm_addr;
  vgpa_pkg::cell_t cm_wd;

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_addr] <= cm_wd;
    if (cm_re) cell_rd_r <= cell_mem[cm_addr];
  end

  // origin table, undefined until loaded
  logic [3*CW-1:0]              org_mem [vgpa_pkg::MAX_SOURCES];
  logic [3*CW-1:0]              org_rd_r;
  logic                         org_we, org_re, org_ok_r;
  logic [vgpa_pkg::SRC_AW-1:0]  org_addr;

  always_ff @(posedge clk) begin
    if (org_we) org_mem[org_addr] <= {f_oz, f_oy, f_ox};
    if (org_re) org_rd_r <= org_mem[org_addr];
  end

  logic in_acc, out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign in_tready = (state_r == vgpa_pkg::ST_IDLE);

  // insert slot search: first match or first empty slot
  logic          slot_ok;
  logic [LW-1:0] new_list;
  always_comb begin
    logic done;
    done     = 1'b0;
    slot_ok  = 1'b0;
    new_list = cell_rd_r.list;
    for (int i = 0; i < vgpa_pkg::SOURCE_SLOTS; i++) begin
      if (!done) begin
        if (cell_rd_r.list[i*IW +: IW] == sid_r) begin
          done = 1'b1;
          slot_ok = 1'b1;
        end else if (cell_rd_r.list[i*IW +: IW] == '0) begin
          done = 1'b1;
          slot_ok = 1'b1;
          new_list[i*IW +: IW] = sid_r;
        end
      end
    end
  end

  // divider step
  logic [NW:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_r[NW-1:0], quo_r[SW-1]};
  assign q_bit  = rem_sh >= {1'b0, work_r.count};

  logic signed [SW-1:0] div_src;
  always_comb begin
    unique case (axis_r)
      2'd0:    div_src = work_r.sum_x;
      2'd1:    div_src = work_r.sum_y;
      default: div_src = work_r.sum_z;
    endcase
  end

  logic [SW-1:0] quo_fin;
  assign quo_fin = {quo_r[SW-2:0], q_bit};

  logic [LW-1:0] list_sh;
  assign list_sh = list_r >> IW;

  // output register
  logic          emit;
  logic [1:0]    emit_kind;
  logic [143:0]  emit_data;
  logic          emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata <= emit_data;
      out_tuser <= emit_kind;
      out_tlast <= emit_last;
    end
  end

  // next state and memory controls
  always_comb begin
    state_nxt = state_r;
    cm_re     = 1'b0;
    cm_we     = 1'b0;
    cm_addr   = addr_r;
    cm_wd     = '0;
    org_we    = 1'b0;
    org_re    = 1'b0;
    org_addr  = vgpa_pkg::SRC_AW'(f_sid);
    emit      = 1'b0;
    emit_kind = vgpa_pkg::KIND_EMPTY;
    emit_data = '0;
    emit_last = 1'b1;
    unique case (state_r)
      vgpa_pkg::ST_CLEAR: begin
        cm_we   = 1'b1;
        cm_addr = clr_r[AW-1:0];
        if (clr_r == (AW+1)'(vgpa_pkg::CELLS - 1)) state_nxt = vgpa_pkg::ST_IDLE;
      end
      vgpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (vgpa_pkg::cmd_t'(in_tuser))
            vgpa_pkg::CMD_LOAD:   org_we = (32'(f_sid) < vgpa_pkg::MAX_SOURCES);
            vgpa_pkg::CMD_INSERT: state_nxt = vgpa_pkg::ST_INS_RD;
            vgpa_pkg::CMD_READ:   state_nxt = vgpa_pkg::ST_RD_RD;
            default: ;
          endcase
        end
      end
      vgpa_pkg::ST_INS_RD: begin
        if (ok_r) begin
          cm_re = 1'b1;
          state_nxt = vgpa_pkg::ST_INS_EVAL;
        end else begin
          state_nxt = vgpa_pkg::ST_RAW;
        end
      end
      vgpa_pkg::ST_INS_EVAL: begin
        if (cell_rd_r.count == vgpa_pkg::COUNT_MAX || !slot_ok) begin
          state_nxt = vgpa_pkg::ST_RAW;
        end else begin
          cm_we       = 1'b1;
          cm_wd.count = cell_rd_r.count + NW'(1);
          cm_wd.sum_x = cell_rd_r.sum_x + SW'(px_r);
          cm_wd.sum_y = cell_rd_r.sum_y + SW'(py_r);
          cm_wd.sum_z = cell_rd_r.sum_z + SW'(pz_r);
          cm_wd.list  = new_list;
          state_nxt   = vgpa_pkg::ST_IDLE;
        end
      end
      vgpa_pkg::ST_RAW: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = vgpa_pkg::KIND_RAW;
          emit_data = {pz_r, py_r, px_r, oz_r, oy_r, ox_r};
          state_nxt = vgpa_pkg::ST_IDLE;
        end
      end
      vgpa_pkg::ST_RD_RD: begin
        if (ok_r) begin
          cm_re = 1'b1;
          state_nxt = vgpa_pkg::ST_RD_EVAL;
        end else begin
          state_nxt = vgpa_pkg::ST_EMPTY;
        end
      end
      vgpa_pkg::ST_RD_EVAL: begin
        if (cell_rd_r.count == '0 || cell_rd_r.list[IW-1:0] == '0) begin
          state_nxt = vgpa_pkg::ST_EMPTY;
        end else begin
          state_nxt = vgpa_pkg::ST_DIV;
        end
      end
      vgpa_pkg::ST_DIV: begin
        if (dcnt_r == 6'(SW) && axis_r == 2'd2) state_nxt = vgpa_pkg::ST_ORG_RD;
      end
      vgpa_pkg::ST_ORG_RD: begin
        org_re    = 1'b1;
        org_addr  = vgpa_pkg::SRC_AW'(list_r[IW-1:0]);
        state_nxt = vgpa_pkg::ST_ORG_OUT;
      end
      vgpa_pkg::ST_ORG_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = vgpa_pkg::KIND_AVG;
          emit_data = {avg_r[2], avg_r[1], avg_r[0], org_ok_r ? org_rd_r : '0};
          emit_last = (list_sh[IW-1:0] == '0);
          state_nxt = emit_last ? vgpa_pkg::ST_IDLE : vgpa_pkg::ST_ORG_RD;
        end
      end
      vgpa_pkg::ST_EMPTY: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = vgpa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vgpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vgpa_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == vgpa_pkg::ST_CLEAR) clr_r <= clr_r + (AW+1)'(1);
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sid_r <= f_sid;
      ox_r <= f_ox; oy_r <= f_oy; oz_r <= f_oz;
      px_r <= f_px; py_r <= f_py; pz_r <= f_pz;
      if (vgpa_pkg::cmd_t'(in_tuser) == vgpa_pkg::CMD_READ) begin
        ok_r   <= rd_ok;
        addr_r <= {f_rx[vgpa_pkg::GX_W-1:0], f_ry[vgpa_pkg::GY_W-1:0],
                   f_rz[vgpa_pkg::GZ_W-1:0]};
      end else begin
        ok_r   <= vox_ok;
        addr_r <= {vx[vgpa_pkg::GX_W-1:0], vy[vgpa_pkg::GY_W-1:0], vz[vgpa_pkg::GZ_W-1:0]};
      end
    end
    if (org_re) org_ok_r <= (32'(list_r[IW-1:0]) < vgpa_pkg::MAX_SOURCES);
    if (state_r == vgpa_pkg::ST_ORG_OUT && out_free) list_r <= list_sh;
    if (state_r == vgpa_pkg::ST_RD_EVAL) begin
      // start divider on x; dcnt 0 means load the magnitude
      work_r <= cell_rd_r;
      list_r <= cell_rd_r.list;
      axis_r <= 2'd0;
      dcnt_r <= '0;
    end else if (state_r == vgpa_pkg::ST_DIV) begin
      if (dcnt_r == '0) begin
        neg_r  <= div_src[SW-1];
        quo_r  <= div_src[SW-1] ? -div_src : div_src;
        rem_r  <= '0;
        dcnt_r <= 6'd1;
      end else begin
        rem_r <= q_bit ? rem_sh - {1'b0, work_r.count} : rem_sh;
        quo_r <= quo_fin;
        if (dcnt_r == 6'(SW)) begin
          avg_r[axis_r] <= neg_r ? -quo_fin[CW-1:0] : quo_fin[CW-1:0];
          axis_r <= axis_r + 2'd1;
          dcnt_r <= '0;
        end else begin
          dcnt_r <= dcnt_r + 6'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// testbench for voxel_grid_point_averager: directed, shared-voxel and random tests
// checked against a cycle-free predictor of the voxel store; depends on design/vgpa_pkg.sv
`timescale 1ns / 100ps
module testbench;

  localparam int  HALF_PERIOD = 6;
  localparam int  CYCLE_LIMIT = 6000000;   // clearing pass plus every item at its slowest, with margin
  localparam int  DRAIN_WAIT  = 400;       // read of a full voxel runs well under this

  typedef struct {
    vgpa_pkg::cmd_t     cmd;
    logic [5:0]         sid;
    logic signed [23:0] ox, oy, oz, px, py, pz;
    logic [6:0]         rx, ry;
    logic [5:0]         rz;
  } voxel_cmd_t;

  typedef struct {
    vgpa_pkg::kind_t    kind;
    logic signed [23:0] ox, oy, oz, px, py, pz;
    logic               last;
  } voxel_beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_addr = '0;
  logic [23:0]  cfg_data = '0;

  voxel_grid_point_averager u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // predictor state: registers, origin table and a sparse copy of the cell store
  logic signed [23:0] ref_x, ref_y, ref_z;
  logic signed [23:0] org_x [vgpa_pkg::MAX_SOURCES];
  logic signed [23:0] org_y [vgpa_pkg::MAX_SOURCES];
  logic signed [23:0] org_z [vgpa_pkg::MAX_SOURCES];
  bit                 org_loaded [vgpa_pkg::MAX_SOURCES];
  int                 vox_count [int];
  longint             vox_sum_x [int], vox_sum_y [int], vox_sum_z [int];
  logic [59:0]        vox_ids [int];
  int                 hot_cells [$];

  voxel_beat_t pending_beats [$];
  int  idle_pct  = 0;
  int  stall_pct = 0;
  int  mismatches = 0;
  int  beats_seen = 0;
  int  items_sent = 0;
  int  raw_seen = 0, avg_seen = 0, empty_seen = 0;
  longint cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic int axis_index(logic signed [23:0] p, logic signed [23:0] r, int half);
    longint d;
    d = longint'(p) - longint'(r);
    return int'(d / vgpa_pkg::VOXEL_STEP) + half;
  endfunction

  function automatic void push_beat(vgpa_pkg::kind_t k, logic signed [23:0] ox, oy, oz,
                                    px, py, pz, logic last);
    voxel_beat_t b;
    b.kind = k; b.ox = ox; b.oy = oy; b.oz = oz;
    b.px = px; b.py = py; b.pz = pz; b.last = last;
    pending_beats.push_back(b);
  endfunction

  function automatic void predict_insert(voxel_cmd_t it);
    int vx, vy, vz, c, slot;
    logic [59:0] ids;
    logic [5:0]  s;
    bit          ok;
    vx = axis_index(it.px, ref_x, vgpa_pkg::GRID_X / 2);
    vy = axis_index(it.py, ref_y, vgpa_pkg::GRID_Y / 2);
    vz = axis_index(it.pz, ref_z, vgpa_pkg::GRID_Z / 2);
    // outside the grid on any axis: raw bypass
    if (vx < 0 || vx >= vgpa_pkg::GRID_X || vy < 0 || vy >= vgpa_pkg::GRID_Y ||
        vz < 0 || vz >= vgpa_pkg::GRID_Z) begin
      push_beat(vgpa_pkg::KIND_RAW, it.ox, it.oy, it.oz, it.px, it.py, it.pz, 1'b1);
      return;
    end
    c = (vx * vgpa_pkg::GRID_Y + vy) * vgpa_pkg::GRID_Z + vz;
    if (!vox_count.exists(c)) begin
      vox_count[c] = 0; vox_sum_x[c] = 0; vox_sum_y[c] = 0; vox_sum_z[c] = 0;
      vox_ids[c] = '0;
      hot_cells.push_back(c);
    end
    // saturated count: bypass, cell untouched
    if (vox_count[c] >= 65535) begin
      push_beat(vgpa_pkg::KIND_RAW, it.ox, it.oy, it.oz, it.px, it.py, it.pz, 1'b1);
      return;
    end
    ids = vox_ids[c];
    ok = 1'b0;
    for (slot = 0; slot < vgpa_pkg::SOURCE_SLOTS; slot++) begin
      s = ids[6*slot +: 6];
      if (s == it.sid) begin
        ok = 1'b1;
        break;
      end
      if (s == 6'd0) begin
        ids[6*slot +: 6] = it.sid;
        ok = 1'b1;
        break;
      end
    end
    // no slot left for a new source: bypass
    if (!ok) begin
      push_beat(vgpa_pkg::KIND_RAW, it.ox, it.oy, it.oz, it.px, it.py, it.pz, 1'b1);
      return;
    end
    vox_ids[c] = ids;
    vox_count[c]++;
    vox_sum_x[c] += longint'(it.px);
    vox_sum_y[c] += longint'(it.py);
    vox_sum_z[c] += longint'(it.pz);
  endfunction

  function automatic void predict_read(voxel_cmd_t it);
    int c, slot, n_ids;
    logic [5:0] s, id_list [vgpa_pkg::SOURCE_SLOTS];
    logic signed [23:0] ax, ay, az;
    c = (int'(it.rx) * vgpa_pkg::GRID_Y + int'(it.ry)) * vgpa_pkg::GRID_Z + int'(it.rz);
    n_ids = 0;
    if (vox_count.exists(c)) begin
      for (slot = 0; slot < vgpa_pkg::SOURCE_SLOTS; slot++) begin
        s = vox_ids[c][6*slot +: 6];
        if (s == 6'd0) break;
        id_list[n_ids++] = s;
      end
    end
    // empty voxel, or points only from id zero
    if (!vox_count.exists(c) || vox_count[c] == 0 || n_ids == 0) begin
      push_beat(vgpa_pkg::KIND_EMPTY, '0, '0, '0, '0, '0, '0, 1'b1);
      return;
    end
    ax = 24'(vox_sum_x[c] / vox_count[c]);
    ay = 24'(vox_sum_y[c] / vox_count[c]);
    az = 24'(vox_sum_z[c] / vox_count[c]);
    for (slot = 0; slot < n_ids; slot++)
      push_beat(vgpa_pkg::KIND_AVG, org_x[id_list[slot]], org_y[id_list[slot]],
                org_z[id_list[slot]], ax, ay, az, slot == n_ids - 1);
  endfunction

  function automatic void predict_item(voxel_cmd_t it);
    case (it.cmd)
      vgpa_pkg::CMD_LOAD: begin
        org_x[it.sid] = it.ox; org_y[it.sid] = it.oy; org_z[it.sid] = it.oz;
        org_loaded[it.sid] = 1'b1;
      end
      vgpa_pkg::CMD_INSERT: predict_insert(it);
      vgpa_pkg::CMD_READ:   predict_read(it);
      default: ;  // unknown command is dropped
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  // one input beat, driven at the falling edge, accepted at a rising edge
  task automatic send_item(voxel_cmd_t it);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = it.cmd;
    in_tdata  = {6'd0, it.rz, it.ry, it.rx, it.pz, it.py, it.px, it.oz, it.oy, it.ox, it.sid};
    do @(posedge clk); while (!in_tready);
    predict_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(vgpa_pkg::reg_idx_t idx, logic signed [23:0] val);
    cfg_valid = 1'b1;
    cfg_addr  = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vgpa_pkg::REG_REF_X: ref_x = val;
      vgpa_pkg::REG_REF_Y: ref_y = val;
      default:             ref_z = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sender holds off until all results are back, then lets accepted inserts settle
  task automatic drain();
    stop_sending();
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_refs(logic signed [23:0] rx, ry, rz);
    drain();
    write_reg(vgpa_pkg::REG_REF_X, rx);
    write_reg(vgpa_pkg::REG_REF_Y, ry);
    write_reg(vgpa_pkg::REG_REF_Z, rz);
  endtask

  // ---------------------------------------------------------------- item builders
  function automatic logic signed [23:0] coord_in(int v, int half, logic signed [23:0] r);
    longint base;
    base = longint'(r) + longint'(v - half) * vgpa_pkg::VOXEL_STEP;
    if (v >= half) base += $urandom_range(0, vgpa_pkg::VOXEL_STEP - 1);
    else           base -= $urandom_range(0, vgpa_pkg::VOXEL_STEP - 1);
    return 24'(base);
  endfunction

  function automatic voxel_cmd_t blank_cmd(vgpa_pkg::cmd_t c);
    voxel_cmd_t it;
    it.cmd = c;
    it.sid = 6'($urandom);
    {it.ox, it.oy, it.oz} = {24'($urandom), 24'($urandom), 24'($urandom)};
    {it.px, it.py, it.pz} = {24'($urandom), 24'($urandom), 24'($urandom)};
    it.rx = 7'($urandom); it.ry = 7'($urandom); it.rz = 6'($urandom);
    return it;
  endfunction

  function automatic logic [5:0] known_source();
    logic [5:0] s;
    if ($urandom_range(19) == 0) return 6'd0;
    do s = 6'($urandom); while (!org_loaded[s] || s == 6'd0);
    return s;
  endfunction

  function automatic voxel_cmd_t insert_at(int c, logic [5:0] sid);
    voxel_cmd_t it;
    it = blank_cmd(vgpa_pkg::CMD_INSERT);
    it.sid = sid;
    it.px = coord_in(c / (vgpa_pkg::GRID_Y * vgpa_pkg::GRID_Z), vgpa_pkg::GRID_X / 2, ref_x);
    it.py = coord_in((c / vgpa_pkg::GRID_Z) % vgpa_pkg::GRID_Y, vgpa_pkg::GRID_Y / 2, ref_y);
    it.pz = coord_in(c % vgpa_pkg::GRID_Z, vgpa_pkg::GRID_Z / 2, ref_z);
    return it;
  endfunction

  function automatic voxel_cmd_t read_at(int c);
    voxel_cmd_t it;
    it = blank_cmd(vgpa_pkg::CMD_READ);
    it.rx = 7'(c / (vgpa_pkg::GRID_Y * vgpa_pkg::GRID_Z));
    it.ry = 7'((c / vgpa_pkg::GRID_Z) % vgpa_pkg::GRID_Y);
    it.rz = 6'(c % vgpa_pkg::GRID_Z);
    return it;
  endfunction

  function automatic int cell_of(int x, int y, int z);
    return (x * vgpa_pkg::GRID_Y + y) * vgpa_pkg::GRID_Z + z;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    voxel_cmd_t it;
    int c, i;
    set_refs('0, '0, '0);
    // origins for ids 1..11 and the top id
    for (i = 1; i <= 11; i++) begin
      it = blank_cmd(vgpa_pkg::CMD_LOAD); it.sid = 6'(i);
      send_item(it);
    end
    it = blank_cmd(vgpa_pkg::CMD_LOAD); it.sid = 6'd63;
    it.ox = 24'sh7FFFFF; it.oy = 24'sh800000; it.oz = 24'sh7FFFFF;
    send_item(it);
    // unknown command
    send_item(blank_cmd(vgpa_pkg::CMD_NONE));
    // extreme coordinates fall outside the grid
    it = blank_cmd(vgpa_pkg::CMD_INSERT); it.sid = 6'd1;
    it.px = 24'sh7FFFFF; it.py = 24'sh800000; it.pz = 24'sh7FFFFF;
    send_item(it);
    it.px = 24'sh800000; it.py = 24'sh7FFFFF; it.pz = 24'sh800000;
    send_item(it);
    // fill one voxel past its source slots, then an id zero point
    c = cell_of(64, 64, 32);
    for (i = 1; i <= 11; i++) send_item(insert_at(c, 6'(i)));
    send_item(insert_at(c, 6'd0));
    // id zero alone leaves a voxel that reads as empty
    send_item(insert_at(cell_of(0, 127, 0), 6'd0));
    send_item(read_at(cell_of(0, 127, 0)));
    send_item(insert_at(cell_of(127, 0, 63), 6'd63));
    send_item(read_at(c));
    send_item(read_at(cell_of(127, 0, 63)));
    send_item(read_at(cell_of(127, 127, 63)));
    send_item(read_at(cell_of(0, 0, 0)));
    drain();
  endtask

  // many points from one source into one voxel, a second source, then a read
  task automatic test_shared_voxel();
    int c, i;
    c = cell_of(20, 100, 5);
    idle_pct = 0; stall_pct = 0;
    for (i = 0; i < 20; i++) send_item(insert_at(c, 6'd3));
    send_item(insert_at(c, 6'd4));
    send_item(read_at(c));
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    voxel_cmd_t it;
    int i, pick, c;
    int hot [6];
    idle_pct = idle; stall_pct = stall;
    for (i = 0; i < 6; i++)
      hot[i] = cell_of($urandom_range(vgpa_pkg::GRID_X - 1), $urandom_range(vgpa_pkg::GRID_Y - 1),
                       $urandom_range(vgpa_pkg::GRID_Z - 1));
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        it = blank_cmd(vgpa_pkg::CMD_LOAD);
      end else if (pick < 14) begin
        it = blank_cmd(vgpa_pkg::CMD_NONE);
      end else if (pick < 64) begin
        // mostly points that land in a few busy voxels
        c = hot[$urandom_range(5)];
        if ($urandom_range(3) == 0 && hot_cells.size() != 0)
          c = hot_cells[$urandom_range(hot_cells.size() - 1)];
        it = insert_at(c, known_source());
        if ($urandom_range(7) == 0) begin
          it.px = 24'($urandom); it.py = 24'($urandom); it.pz = 24'($urandom);
        end
      end else begin
        c = ($urandom_range(2) == 0) ? cell_of($urandom_range(127), $urandom_range(127),
                                               $urandom_range(63))
                                     : hot[$urandom_range(5)];
        it = read_at(c);
      end
      send_item(it);
    end
    drain();
  endtask

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    voxel_beat_t exp_b;
    voxel_beat_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_beats.size());
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = vgpa_pkg::kind_t'(out_tuser);
      {got.pz, got.py, got.px, got.oz, got.oy, got.ox} = out_tdata;
      got.last = out_tlast;
      beats_seen++;
      case (got.kind)
        vgpa_pkg::KIND_RAW: raw_seen++;
        vgpa_pkg::KIND_AVG: avg_seen++;
        default:            empty_seen++;
      endcase
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d pt %0d %0d %0d", got.kind,
                   got.px, got.py, got.pz);
      end else begin
        exp_b = pending_beats.pop_front();
        if (got.kind != exp_b.kind || got.ox != exp_b.ox || got.oy != exp_b.oy ||
            got.oz != exp_b.oz || got.px != exp_b.px || got.py != exp_b.py ||
            got.pz != exp_b.pz || got.last != exp_b.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at beat %0d", beats_seen);
            $display("  expected kind %0d org %0d %0d %0d pt %0d %0d %0d last %0b",
                     exp_b.kind, exp_b.ox, exp_b.oy, exp_b.oz, exp_b.px, exp_b.py,
                     exp_b.pz, exp_b.last);
            $display("  actual   kind %0d org %0d %0d %0d pt %0d %0d %0d last %0b",
                     got.kind, got.ox, got.oy, got.oz, got.px, got.py, got.pz, got.last);
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk)
    out_tready = ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------- sequence
  initial begin
    ref_x = '0; ref_y = '0; ref_z = '0;
    for (int i = 0; i < vgpa_pkg::MAX_SOURCES; i++) begin
      org_x[i] = '0; org_y[i] = '0; org_z[i] = '0; org_loaded[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_shared_voxel();
    // several phases of offsets and idling, extremes of each register among them
    set_refs(24'sh7FFFFF, 24'sh800000, 24'sh000000);
    test_random(25, 0, 0);
    set_refs(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    test_random(25, 53, 0);
    set_refs(24'($urandom_range(4000)) - 24'sd2000, 24'($urandom_range(4000)) - 24'sd2000,
             24'sh800000);
    test_random(45, 0, 53);
    set_refs('0, '0, '0);
    test_random(45, 11, 11);
    set_refs(24'($urandom), 24'($urandom), 24'($urandom));
    test_random(25, 53, 53);

    stop_sending();
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("sent %0d items over %0d cycles; %0d result beats (%0d raw, %0d averaged, %0d empty)",
             items_sent, cycles, beats_seen, raw_seen, avg_seen, empty_seen);
    $display("covered out-of-grid, full source list, id zero, shared voxels and offset extremes");
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/vgpa_pkg.sv
design/voxel_grid_point_averager.sv
sim/testbench.sv
